@@ rtl/pcvs_pkg.sv @@
`timescale 1ns / 1ps

package pcvs_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]  PULSE_TICKS_RST = 8'd3;
  localparam logic [15:0] BUSY_TICKS_RST  = 16'd10000;
  localparam logic [3:0]  MAX_CODE_RST    = 4'd13;
  localparam logic [3:0]  WIFI_CODE_RST   = 4'd0;

  // operation codes carried in the input tuser
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_ENQUEUE = 1'b1;

  typedef enum logic [1:0] {
    CFG_PULSE_TICKS = 2'd0,
    CFG_BUSY_TICKS  = 2'd1,
    CFG_MAX_CODE    = 2'd2,
    CFG_WIFI_CODE   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_CLK_HIGH = 3'd1,
    PH_CLK_LOW  = 3'd2,
    PH_DAT_HIGH = 3'd3,
    PH_DAT_LOW  = 3'd4,
    PH_FINISH   = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0]  pulse_ticks;
    logic [15:0] busy_ticks;
    logic [3:0]  max_code;
    logic [3:0]  wifi_code;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic [3:0]         pulses_left;
    logic [7:0]         phase_timer;
    logic               busy_flag;
    logic [15:0]        busy_timer;
    logic               clk_pin;
    logic               dat_pin;
    logic [PTR_W-1:0]   rd_ptr;
    logic [PTR_W-1:0]   wr_ptr;
    logic [CNT_W-1:0]   count;
  } state_t;

  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] ptr;
    logic [3:0]       code;
  } store_wr_t;

  typedef struct packed {
    logic [CNT_W-1:0] queue_count;
    logic             wifi_event;
    logic             accepted;
    logic             busy_res;
    logic             dat_level;
    logic             clk_level;
  } result_t;

endpackage

@@ rtl/pulse_count_voice_sender_core.sv @@
`timescale 1ns / 1ps

// channel | dir | tdata (low bit first)                          | tuser
// --------+-----+------------------------------------------------+-----------------
// in_     | in  | voice_code[3:0], zero pad to 8 bits            | operation
// out_    | out | clk_level, dat_level, busy_res, accepted,      | -
//         |     | wifi_event, queue_count[4:0], zero pad to 16   |
// cfg_    | in  | cfg_addr selects register, cfg_wdata 16 bits   | -
//
// one item per cycle unless out_ stalls: each tick or enqueue is a single
// queue or phase update between the state registers and the output register
// a result shows on out_ the cycle after its input transfer
// the output register lets a new input transfer land while the last result
// drains; in_tready drops only when that register is full and not taken
// reset (rst_n low, synchronous) empties the queue, idles the sequencer and
// loads register defaults; the code store itself is not cleared

module pulse_count_voice_sender_core import pcvs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [3:0] voice_code
  input  logic        in_tuser,   // [0] operation
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] clk_level, [1] dat_level, [2] busy_res,
                                  // [3] accepted, [4] wifi_event, [9:5] queue_count
  // register writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  cfg_t      cfg_r;
  state_t    state_r;
  state_t    state_nxt;
  store_wr_t store_wr;
  result_t   res;
  logic      in_xfer;
  logic      out_valid_r;
  logic      out_valid_nxt;
  result_t   out_data_r;
  logic [3:0] head_code;

  // queue storage, one write and one read port
  logic [3:0] code_store [QUEUE_DEPTH];

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign head_code = code_store[state_r.rd_ptr];

  pcvs_step u_step (
    .cfg        (cfg_r),
    .cur        (state_r),
    .operation  (in_tuser),
    .voice_code (in_tdata[3:0]),
    .head_code  (head_code),
    .nxt        (state_nxt),
    .store_wr   (store_wr),
    .res        (res)
  );

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_ticks <= PULSE_TICKS_RST;
      cfg_r.busy_ticks  <= BUSY_TICKS_RST;
      cfg_r.max_code    <= MAX_CODE_RST;
      cfg_r.wifi_code   <= WIFI_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PULSE_TICKS: cfg_r.pulse_ticks <= cfg_wdata[7:0];
        CFG_BUSY_TICKS:  cfg_r.busy_ticks  <= cfg_wdata;
        CFG_MAX_CODE:    cfg_r.max_code    <= cfg_wdata[3:0];
        CFG_WIFI_CODE:   cfg_r.wifi_code   <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // sequencer and queue pointers advance on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_IDLE, default: '0};
    end else if (in_xfer) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && store_wr.en) begin
      code_store[store_wr.ptr] <= store_wr.code;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(16 - $bits(result_t)){1'b0}}, out_data_r};

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.busy_flag |-> (state_r.phase == PH_IDLE && !state_r.clk_pin && !state_r.dat_pin))
    else $error("send in progress during busy window");

  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tuser == OP_ENQUEUE && res.accepted)
      |=> state_r.count == CNT_W'($past(state_r.count) + 1'b1))
    else $error("stored code not counted");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.accepted && out_data_r.wifi_event))
    else $error("accepted and wifi event in one result");

endmodule

@@ rtl/pcvs_step.sv @@
`timescale 1ns / 1ps

module pcvs_step import pcvs_pkg::*; (
  input  cfg_t       cfg,
  input  state_t     cur,
  input  logic       operation,
  input  logic [3:0] voice_code,
  input  logic [3:0] head_code,
  output state_t     nxt,
  output store_wr_t  store_wr,
  output result_t    res
);

  logic       go;
  logic       stored;
  logic       wifi;
  logic [7:0] timer_dec;
  logic       level_done;
  logic       do_pop;

  // shared level timer countdown, used by the holding phases
  assign timer_dec  = (cur.phase_timer != 8'd0) ? cur.phase_timer - 8'd1 : 8'd0;
  assign level_done = (timer_dec == 8'd0);

  // next state
  always_comb begin
    nxt      = cur;
    store_wr = '0;
    stored   = 1'b0;
    wifi     = 1'b0;
    go       = 1'b1;
    do_pop   = 1'b0;
    if (operation == OP_ENQUEUE) begin
      if (voice_code <= cfg.max_code && cur.count < CNT_W'(QUEUE_DEPTH)) begin
        stored        = 1'b1;
        store_wr.en   = 1'b1;
        store_wr.ptr  = cur.wr_ptr;
        store_wr.code = voice_code;
        nxt.wr_ptr    = (cur.wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : cur.wr_ptr + 1'b1;
        nxt.count     = cur.count + 1'b1;
      end
    end else begin
      if (cur.busy_flag) begin
        if (cur.busy_timer != 16'd0) begin
          nxt.busy_timer = cur.busy_timer - 16'd1;
          go = 1'b0;
        end else begin
          nxt.busy_flag = 1'b0;
        end
      end
      if (go && cur.count != '0) begin
        case (cur.phase)
          PH_CLK_HIGH: begin
            nxt.clk_pin     = 1'b1;
            nxt.phase_timer = cfg.pulse_ticks;
            nxt.phase       = PH_CLK_LOW;
          end
          PH_CLK_LOW: begin
            nxt.phase_timer = timer_dec;
            if (level_done) begin
              nxt.clk_pin     = 1'b0;
              nxt.phase_timer = cfg.pulse_ticks;
              nxt.phase       = PH_DAT_HIGH;
            end
          end
          PH_DAT_HIGH: begin
            nxt.phase_timer = timer_dec;
            if (level_done) begin
              nxt.pulses_left = cur.pulses_left - 4'd1;
              nxt.dat_pin     = 1'b1;
              nxt.phase_timer = cfg.pulse_ticks;
              nxt.phase       = PH_DAT_LOW;
            end
          end
          PH_DAT_LOW: begin
            nxt.phase_timer = timer_dec;
            if (level_done) begin
              nxt.dat_pin     = 1'b0;
              nxt.phase       = (cur.pulses_left == 4'd0) ? PH_FINISH : PH_DAT_HIGH;
              nxt.phase_timer = cfg.pulse_ticks;
            end
          end
          PH_FINISH: begin
            nxt.phase_timer = timer_dec;
            if (level_done) begin
              nxt.clk_pin     = 1'b0;
              nxt.dat_pin     = 1'b0;
              nxt.pulses_left = 4'd0;
              nxt.phase       = PH_IDLE;
              nxt.busy_flag   = 1'b1;
              nxt.busy_timer  = cfg.busy_ticks;
              do_pop          = 1'b1;
              wifi            = (head_code == cfg.wifi_code);
            end
          end
          default: begin
            nxt.clk_pin = 1'b0;
            nxt.dat_pin = 1'b0;
            nxt.phase   = PH_IDLE;
            if (head_code == 4'd0) begin
              // zero code is dropped without a send
              do_pop = 1'b1;
            end else begin
              nxt.pulses_left = head_code;
              nxt.phase_timer = cfg.pulse_ticks;
              nxt.phase       = PH_CLK_HIGH;
            end
          end
        endcase
        if (do_pop) begin
          nxt.rd_ptr = (cur.rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : cur.rd_ptr + 1'b1;
          nxt.count  = cur.count - 1'b1;
        end
      end
    end
  end

  // result fields
  always_comb begin
    res.clk_level   = nxt.clk_pin;
    res.dat_level   = nxt.dat_pin;
    res.busy_res    = nxt.busy_flag;
    res.accepted    = stored;
    res.wifi_event  = wifi;
    res.queue_count = nxt.count;
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import pcvs_pkg::*;

  // mirror of the voice sender: register copies, code queue, pin sequencer,
  // plus the results still due on the out_ channel
  class voice_sender_mirror;
    logic [7:0]       pulse_ticks;
    logic [15:0]      busy_ticks;
    logic [3:0]       max_code;
    logic [3:0]       wifi_code;
    logic [3:0]       code_fifo [QUEUE_DEPTH];
    logic [PTR_W-1:0] rd_ptr;
    logic [PTR_W-1:0] wr_ptr;
    logic [CNT_W-1:0] count;
    phase_t           phase;
    logic [3:0]       pulses_left;
    logic [7:0]       level_timer;
    logic             busy_flag;
    logic [15:0]      busy_timer;
    logic             clk_pin;
    logic             dat_pin;
    result_t          results_due[$];
    int               failures;

    function new();
      pulse_ticks = PULSE_TICKS_RST;
      busy_ticks  = BUSY_TICKS_RST;
      max_code    = MAX_CODE_RST;
      wifi_code   = WIFI_CODE_RST;
      rd_ptr      = '0;
      wr_ptr      = '0;
      count       = '0;
      phase       = PH_IDLE;
      pulses_left = '0;
      level_timer = '0;
      busy_flag   = 1'b0;
      busy_timer  = '0;
      clk_pin     = 1'b0;
      dat_pin     = 1'b0;
      failures    = 0;
    endfunction

    function void set_regs(logic [7:0] pt, logic [15:0] bt, logic [3:0] mc, logic [3:0] wc);
      pulse_ticks = pt;
      busy_ticks  = bt;
      max_code    = mc;
      wifi_code   = wc;
    endfunction

    // a zero hold time behaves like one tick
    function bit level_held();
      if (level_timer != 0)
        level_timer--;
      return level_timer == 0;
    endfunction

    function void pop_code();
      if (count != 0) begin
        rd_ptr++;
        count--;
      end
    endfunction

    // one sequencer step, returns the wifi event flag
    function bit run_tick();
      logic [3:0] head;
      if (busy_flag) begin
        if (busy_timer != 0) begin
          busy_timer--;
          return 1'b0;
        end
        busy_flag = 1'b0;
      end
      if (count == 0)
        return 1'b0;
      head = code_fifo[rd_ptr];
      case (phase)
        PH_CLK_HIGH: begin
          clk_pin     = 1'b1;
          level_timer = pulse_ticks;
          phase       = PH_CLK_LOW;
        end
        PH_CLK_LOW: begin
          if (!level_held())
            return 1'b0;
          clk_pin     = 1'b0;
          level_timer = pulse_ticks;
          phase       = PH_DAT_HIGH;
        end
        PH_DAT_HIGH: begin
          if (!level_held())
            return 1'b0;
          pulses_left = pulses_left - 4'd1;
          dat_pin     = 1'b1;
          level_timer = pulse_ticks;
          phase       = PH_DAT_LOW;
        end
        PH_DAT_LOW: begin
          if (!level_held())
            return 1'b0;
          dat_pin     = 1'b0;
          phase       = (pulses_left == 0) ? PH_FINISH : PH_DAT_HIGH;
          level_timer = pulse_ticks;
        end
        PH_FINISH: begin
          if (!level_held())
            return 1'b0;
          clk_pin     = 1'b0;
          dat_pin     = 1'b0;
          pulses_left = '0;
          phase       = PH_IDLE;
          busy_flag   = 1'b1;
          busy_timer  = busy_ticks;
          pop_code();
          return head == wifi_code;
        end
        default: begin
          clk_pin = 1'b0;
          dat_pin = 1'b0;
          phase   = PH_IDLE;
          // zero code leaves the queue without any pulse or busy window
          if (head == 0) begin
            pop_code();
            return 1'b0;
          end
          pulses_left = head;
          level_timer = pulse_ticks;
          phase       = PH_CLK_HIGH;
        end
      endcase
      return 1'b0;
    endfunction

    function void note_item(logic op, logic [3:0] code);
      result_t r;
      r = '0;
      if (op == OP_ENQUEUE) begin
        if (code <= max_code && count < QUEUE_DEPTH) begin
          code_fifo[wr_ptr] = code;
          wr_ptr++;
          count++;
          r.accepted = 1'b1;
        end
      end else begin
        r.wifi_event = run_tick();
      end
      r.clk_level   = clk_pin;
      r.dat_level   = dat_pin;
      r.busy_res    = busy_flag;
      r.queue_count = count;
      results_due.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [15:0] data);
      result_t want;
      result_t got;
      if (results_due.size() == 0) begin
        $error("result transfer with nothing expected: %h", data);
        failures++;
        return;
      end
      want = results_due.pop_front();
      got  = data[$bits(result_t)-1:0];
      compare_field("clk_level", want.clk_level, got.clk_level);
      compare_field("dat_level", want.dat_level, got.dat_level);
      compare_field("busy_res", want.busy_res, got.busy_res);
      compare_field("accepted", want.accepted, got.accepted);
      compare_field("wifi_event", want.wifi_event, got.wifi_event);
      compare_field("queue_count", want.queue_count, got.queue_count);
    endfunction

    function int unsigned outstanding();
      return results_due.size();
    endfunction

    // true while codes wait or a busy window still has to run down
    function bit still_sending();
      return count != 0 || busy_flag;
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tuser   = OP_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_addr   = CFG_PULSE_TICKS;
  logic [15:0] cfg_wdata  = '0;

  // percent of cycles the sender holds back and the receiver stalls
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  voice_sender_mirror sender_model;

  pulse_count_voice_sender_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // random receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // outputs are sampled on the falling edge, where they equal the values
  // seen by the next rising edge; a transfer there is checked now
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sender_model.check_result(out_tdata);
  end

  // one input transfer; entered and left right after a rising edge
  task automatic push_item(input logic op, input logic [3:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0000, code};
    do @(negedge clk); while (!in_tready);
    sender_model.note_item(op, code);
    @(posedge clk);
  endtask

  // stop sending and let every expected result come back
  task automatic quiesce();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sender_model.outstanding() != 0);
    repeat (4) @(posedge clk);
  endtask

  // write all four registers on back-to-back cycles
  task automatic load_regs(input logic [7:0] pt, input logic [15:0] bt,
                           input logic [3:0] mc, input logic [3:0] wc);
    logic [15:0] reg_val [4];
    cfg_idx_t    idx;
    reg_val[CFG_PULSE_TICKS] = {8'h00, pt};
    reg_val[CFG_BUSY_TICKS]  = bt;
    reg_val[CFG_MAX_CODE]    = {12'h000, mc};
    reg_val[CFG_WIFI_CODE]   = {12'h000, wc};
    idx = idx.first();
    do begin
      cfg_we    <= 1'b1;
      cfg_addr  <= idx;
      cfg_wdata <= reg_val[idx];
      @(posedge clk);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_we <= 1'b0;
    sender_model.set_regs(pt, bt, mc, wc);
  endtask

  // random mix of enqueues and ticks; a zero code shows up more often
  task automatic run_traffic(input int items, input int enq_pct, input int idle_pct,
                             input int stall_pct, input bit hold_midway);
    logic       op;
    logic [3:0] code;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < items; k++) begin
      // sender waits for the result stream to empty out once
      if (hold_midway && k == items / 2) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (sender_model.outstanding() != 0);
      end
      op   = ($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_TICK;
      code = ($urandom_range(99) < 15) ? 4'd0 : 4'($urandom_range(15));
      push_item(op, code);
    end
  endtask

  // tick until the queue is empty and the busy window is over
  task automatic drain_queue();
    while (sender_model.still_sending())
      push_item(OP_TICK, 4'($urandom_range(15)));
  endtask

  initial begin
    sender_model = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: code above the default limit dropped, zero kept
    push_item(OP_ENQUEUE, 4'd14);
    push_item(OP_ENQUEUE, 4'd0);
    quiesce();

    // directed: fastest timing, no busy window, wifi flag on code 1
    load_regs(8'd1, 16'd0, 4'd13, 4'd1);
    push_item(OP_TICK, 4'd9);        // zero code popped silently
    push_item(OP_TICK, 4'd15);       // empty queue, nothing happens
    push_item(OP_ENQUEUE, 4'd14);    // above max_code
    push_item(OP_ENQUEUE, 4'd1);
    push_item(OP_ENQUEUE, 4'd13);
    repeat (10)
      push_item(OP_TICK, 4'd0);      // full send of code 1, then code 13 starts
    push_item(OP_ENQUEUE, 4'd15);
    quiesce();

    // widest code range, heavy enqueue load to fill the queue
    load_regs(8'd1, 16'd0, 4'd15, 4'd15);
    run_traffic(220, 40, 0, 0, 1'b0);
    quiesce();

    // sparse enqueues, queue runs empty, sender idles
    load_regs(8'd2, 16'd5, 4'd13, 4'd0);
    run_traffic(180, 10, 59, 0, 1'b1);
    quiesce();

    // only zero codes get in, receiver stalls
    load_regs(8'd3, 16'd20, 4'd0, 4'd0);
    run_traffic(120, 50, 0, 59, 1'b0);
    quiesce();

    load_regs(8'd1, 16'd1, 4'd7, 4'd5);
    run_traffic(160, 25, 33, 33, 1'b0);
    quiesce();

    load_regs(8'd2, 16'd3, 4'd15, 4'd9);
    run_traffic(100, 35, 0, 0, 1'b0);
    quiesce();

    // fastest timing to empty the queue quickly
    load_regs(8'd1, 16'd0, 4'd15, 4'd9);
    drain_queue();
    quiesce();

    // slowest levels: the clock high level is held the full 255 ticks
    load_regs(8'd255, 16'd65535, 4'd15, 4'd1);
    push_item(OP_ENQUEUE, 4'd1);
    repeat (256)
      push_item(OP_TICK, 4'($urandom_range(15)));
    quiesce();

    // short levels finish the send, then the longest busy window starts
    load_regs(8'd1, 16'd65535, 4'd15, 4'd1);
    repeat (20)
      push_item(OP_TICK, 4'($urandom_range(15)));

    in_tvalid <= 1'b0;
    do @(posedge clk); while (sender_model.outstanding() != 0);
    repeat (8) @(posedge clk);
    if (sender_model.failures == 0 && sender_model.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
rtl/pcvs_pkg.sv
rtl/pcvs_step.sv
rtl/pulse_count_voice_sender_core.sv
test/testbench.sv
